// File: hdl/rsnp_pkg.sv
// ----------------------------------------------------------------------------
// rsnp_pkg
// Shared types and constants for the ray/sphere nearest pick block.
// ----------------------------------------------------------------------------
package rsnp_pkg;

    localparam int COORD_W = 32;
    localparam int SCALE_W = 31;
    localparam int MAG_W   = 34;
    localparam int PROD_W  = 2 * MAG_W;
    localparam int ACC_W   = 140;
    localparam int ROOT_W  = 32;
    localparam int RAD_W   = 64;
    localparam int STEP_W  = 5;
    localparam int IDX_W   = 3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [IDX_W-1:0] REG_ORIGIN_Z    = 3'd2;
    localparam logic [IDX_W-1:0] REG_DIR_X       = 3'd3;
    localparam logic [IDX_W-1:0] REG_DIR_Y       = 3'd4;
    localparam logic [IDX_W-1:0] REG_DIR_Z       = 3'd5;
    localparam logic [IDX_W-1:0] REG_PICK_MARGIN = 3'd6;

    // MAC step schedule
    localparam logic [STEP_W-1:0] STEP_L0     = 5'd0;
    localparam logic [STEP_W-1:0] STEP_L1     = 5'd1;
    localparam logic [STEP_W-1:0] STEP_L2     = 5'd2;
    localparam logic [STEP_W-1:0] STEP_LR_END = 5'd3;
    localparam logic [STEP_W-1:0] STEP_D0     = 5'd4;
    localparam logic [STEP_W-1:0] STEP_D1     = 5'd5;
    localparam logic [STEP_W-1:0] STEP_D_END  = 5'd6;
    localparam logic [STEP_W-1:0] STEP_B0     = 5'd7;
    localparam logic [STEP_W-1:0] STEP_B1     = 5'd8;
    localparam logic [STEP_W-1:0] STEP_B_END  = 5'd9;
    localparam logic [STEP_W-1:0] STEP_BB_LL  = 5'd10;
    localparam logic [STEP_W-1:0] STEP_BB_LH  = 5'd11;
    localparam logic [STEP_W-1:0] STEP_BB_HL  = 5'd12;
    localparam logic [STEP_W-1:0] STEP_BB_HH  = 5'd13;
    localparam logic [STEP_W-1:0] STEP_LD_LL  = 5'd14;
    localparam logic [STEP_W-1:0] STEP_LD_LH  = 5'd15;
    localparam logic [STEP_W-1:0] STEP_LD_HL  = 5'd16;
    localparam logic [STEP_W-1:0] STEP_Q_END  = 5'd17;

    localparam logic [ROOT_W-1:0]  DIST_MAX = '1;
    localparam logic [SCALE_W-1:0] DIST_SAT = '1;

    localparam logic [COORD_W-1:0] DIR_Z_RESET  = 32'd65536;
    localparam logic [SCALE_W-1:0] MARGIN_RESET = 31'd327680;

    typedef enum logic [1:0] {
        SH_0,
        SH_34,
        SH_68
    } shift_t;

    typedef struct packed {
        logic   en;
        logic   sub;
        shift_t shift;
    } mac_op_t;

endpackage

// File: hdl/rsnp_if.sv
// ----------------------------------------------------------------------------
// rsnp_if
// Channel interfaces: entity words in, pick results out, register writes.
// ----------------------------------------------------------------------------
interface rsnp_ent_if #(parameter int ID_BITS = 16);
    logic                valid;
    logic                ready;
    logic [ID_BITS-1:0]  entity_id;
    logic signed [31:0]  pos_x;
    logic signed [31:0]  pos_y;
    logic signed [31:0]  pos_z;
    logic [30:0]         selection_scale;
    logic                last;

    modport source (output valid, entity_id, pos_x, pos_y, pos_z, selection_scale, last,
                    input ready);
    modport sink   (input valid, entity_id, pos_x, pos_y, pos_z, selection_scale, last,
                    output ready);
endinterface

interface rsnp_res_if #(parameter int ID_BITS = 16);
    logic               valid;
    logic               ready;
    logic               found;
    logic [ID_BITS-1:0] nearest_id;
    logic [30:0]        nearest_distance;

    modport source (output valid, found, nearest_id, nearest_distance, input ready);
    modport sink   (input valid, found, nearest_id, nearest_distance, output ready);
endinterface

interface rsnp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/ray_sphere_nearest_pick.sv
// ----------------------------------------------------------------------------
// ray_sphere_nearest_pick
// Nearest-sphere pick along a configured ray, Q16.16 fixed point.
//
// Channels: ent takes one entity word (id, position, selection scale, last);
// res gives one result word (found, nearest_id, nearest_distance) after each
// entity marked last; cfg writes the seven ray/margin registers and is
// always ready. Configure only while no query is in flight.
// One entity at a time: ent.ready is high only when the sequencer is idle.
// Each entity passes the set-up states S_PREP_R, S_PREP_Y and S_PREP_OC, then
// the shared 34x34 MAC runs: origin inside the sphere: 4 MAC steps plus the
// square root; outside: 18 MAC steps; zero direction: no MAC steps.
// A result waits in an output register; while res stalls, the block still
// takes entities that are not marked last, and holds a last one until the
// register frees.
// Reset returns the registers to their defaults and clears the best hit.
// ----------------------------------------------------------------------------
module ray_sphere_nearest_pick #(
    parameter int ID_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    rsnp_ent_if.sink         ent,
    rsnp_res_if.source       res,
    rsnp_cfg_if.sink         cfg
);

    import rsnp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP_R,
        S_PREP_Y,
        S_PREP_OC,
        S_ISSUE,
        S_DRAIN,
        S_CHECK,
        S_SQRT,
        S_UPDATE
    } state_t;

    state_t                     state_reg;
    logic signed [COORD_W-1:0]  org_reg [3];
    logic signed [COORD_W-1:0]  dir_reg [3];
    logic [SCALE_W-1:0]         margin_reg;

    logic [ID_BITS-1:0]         id_reg;
    logic signed [COORD_W-1:0]  pos_reg [3];
    logic [SCALE_W-1:0]         scale_reg;
    logic                       last_reg;
    logic [31:0]                r_reg;
    logic signed [33:0]         posy_reg;
    logic [MAG_W-1:0]           ocm_reg [3];
    logic [2:0]                 ocs_reg;
    logic [PROD_W-1:0]          lmr_reg;
    logic [63:0]                dd_reg;
    logic [PROD_W-1:0]          bb_reg;
    logic [STEP_W-1:0]          step_reg;
    logic                       hit_reg;
    logic [ROOT_W-1:0]          dist_reg;

    logic [ROOT_W-1:0]          best_dist_reg;
    logic [ID_BITS-1:0]         best_id_reg;
    logic                       any_reg;

    logic                       res_valid_reg;
    logic                       found_reg;
    logic [ID_BITS-1:0]         nid_reg;
    logic [SCALE_W-1:0]         ndist_reg;

    logic [MAG_W-1:0]           dm [3];
    logic [2:0]                 ds;
    logic signed [34:0]         oc_next [3];
    logic                       dir_nz;
    logic [ACC_W-1:0]           acc;
    logic [ACC_W-1:0]           acc_neg;
    logic                       acc_sign;
    mac_op_t                    mop;
    logic [MAG_W-1:0]           ma;
    logic [MAG_W-1:0]           mb;
    logic                       mclr;
    logic                       group_end;
    logic                       sq_start;
    logic                       sq_done;
    logic [ROOT_W-1:0]          sq_root;
    logic                       better;
    logic                       m_any;
    logic [ROOT_W-1:0]          m_dist;
    logic [ID_BITS-1:0]         m_id;
    logic [PROD_W-1:0]          dd_ext;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ds[i] = dir_reg[i][COORD_W-1];
            dm[i] = ds[i] ? MAG_W'(-{{2{dir_reg[i][COORD_W-1]}}, dir_reg[i]})
                          : MAG_W'({{2{1'b0}}, dir_reg[i]});
        end
    end

    assign oc_next[0] = 35'(org_reg[0]) - 35'(pos_reg[0]);
    assign oc_next[1] = 35'(org_reg[1]) - 35'(posy_reg);
    assign oc_next[2] = 35'(org_reg[2]) - 35'(pos_reg[2]);

    assign dir_nz   = (dir_reg[0] != '0) || (dir_reg[1] != '0) || (dir_reg[2] != '0);
    assign acc_sign = acc[ACC_W-1];
    assign acc_neg  = -acc;
    assign dd_ext   = PROD_W'(dd_reg);

    always_comb
    begin
        mop.en    = (state_reg == S_ISSUE);
        mop.sub   = 1'b0;
        mop.shift = SH_0;
        ma        = '0;
        mb        = '0;
        case (step_reg)
            STEP_L0, STEP_L1, STEP_L2:
            begin
                ma = ocm_reg[step_reg[1:0]];
                mb = ocm_reg[step_reg[1:0]];
            end
            STEP_LR_END:
            begin
                ma      = MAG_W'(r_reg);
                mb      = MAG_W'(r_reg);
                mop.sub = 1'b1;
            end
            STEP_D0, STEP_D1, STEP_D_END:
            begin
                ma = dm[2'(step_reg - STEP_D0)];
                mb = dm[2'(step_reg - STEP_D0)];
            end
            STEP_B0, STEP_B1, STEP_B_END:
            begin
                ma      = ocm_reg[2'(step_reg - STEP_B0)];
                mb      = dm[2'(step_reg - STEP_B0)];
                mop.sub = ocs_reg[2'(step_reg - STEP_B0)] ^ ds[2'(step_reg - STEP_B0)];
            end
            STEP_BB_LL:
            begin
                ma = bb_reg[MAG_W-1:0];
                mb = bb_reg[MAG_W-1:0];
            end
            STEP_BB_LH:
            begin
                ma        = bb_reg[MAG_W-1:0];
                mb        = bb_reg[PROD_W-1:MAG_W];
                mop.shift = SH_34;
            end
            STEP_BB_HL:
            begin
                ma        = bb_reg[PROD_W-1:MAG_W];
                mb        = bb_reg[MAG_W-1:0];
                mop.shift = SH_34;
            end
            STEP_BB_HH:
            begin
                ma        = bb_reg[PROD_W-1:MAG_W];
                mb        = bb_reg[PROD_W-1:MAG_W];
                mop.shift = SH_68;
            end
            STEP_LD_LL:
            begin
                ma      = lmr_reg[MAG_W-1:0];
                mb      = dd_ext[MAG_W-1:0];
                mop.sub = 1'b1;
            end
            STEP_LD_LH:
            begin
                ma        = lmr_reg[MAG_W-1:0];
                mb        = dd_ext[PROD_W-1:MAG_W];
                mop.sub   = 1'b1;
                mop.shift = SH_34;
            end
            STEP_LD_HL:
            begin
                ma        = lmr_reg[PROD_W-1:MAG_W];
                mb        = dd_ext[MAG_W-1:0];
                mop.sub   = 1'b1;
                mop.shift = SH_34;
            end
            STEP_Q_END:
            begin
                ma        = lmr_reg[PROD_W-1:MAG_W];
                mb        = dd_ext[PROD_W-1:MAG_W];
                mop.sub   = 1'b1;
                mop.shift = SH_68;
            end
            default:
            begin
                mop.en = 1'b0;
            end
        endcase
    end

    assign group_end = (step_reg == STEP_LR_END) || (step_reg == STEP_D_END) ||
                       (step_reg == STEP_B_END)  || (step_reg == STEP_Q_END);
    assign mclr      = (state_reg == S_PREP_OC) || (state_reg == S_CHECK);
    assign sq_start  = (state_reg == S_CHECK) && (step_reg == STEP_LR_END) && acc_sign;

    rsnp_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mop),
        .a     (ma),
        .b     (mb),
        .clr   (mclr),
        .acc   (acc)
    );

    rsnp_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (acc_neg[RAD_W-1:0]),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign better = hit_reg && (!any_reg || (dist_reg < best_dist_reg));
    assign m_any  = any_reg | better;
    assign m_dist = better ? dist_reg : best_dist_reg;
    assign m_id   = better ? id_reg : best_id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            org_reg[0]    <= '0;
            org_reg[1]    <= '0;
            org_reg[2]    <= '0;
            dir_reg[0]    <= '0;
            dir_reg[1]    <= '0;
            dir_reg[2]    <= DIR_Z_RESET;
            margin_reg    <= MARGIN_RESET;
            step_reg      <= '0;
            hit_reg       <= 1'b0;
            best_dist_reg <= DIST_MAX;
            best_id_reg   <= '0;
            any_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_ORIGIN_X:    org_reg[0] <= cfg.data;
                    REG_ORIGIN_Y:    org_reg[1] <= cfg.data;
                    REG_ORIGIN_Z:    org_reg[2] <= cfg.data;
                    REG_DIR_X:       dir_reg[0] <= cfg.data;
                    REG_DIR_Y:       dir_reg[1] <= cfg.data;
                    REG_DIR_Z:       dir_reg[2] <= cfg.data;
                    REG_PICK_MARGIN: margin_reg <= cfg.data[SCALE_W-1:0];
                    default:         ;
                endcase
            end

            if (res_valid_reg && res.ready)
                res_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (ent.valid)
                        state_reg <= S_PREP_R;
                end
                S_PREP_R:
                begin
                    state_reg <= S_PREP_Y;
                end
                S_PREP_Y:
                begin
                    state_reg <= S_PREP_OC;
                end
                S_PREP_OC:
                begin
                    step_reg <= STEP_L0;
                    if (dir_nz)
                        state_reg <= S_ISSUE;
                    else
                    begin
                        hit_reg   <= 1'b0;
                        state_reg <= S_UPDATE;
                    end
                end
                S_ISSUE:
                begin
                    if (group_end)
                        state_reg <= S_DRAIN;
                    else
                        step_reg <= step_reg + 5'd1;
                end
                S_DRAIN:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    step_reg  <= step_reg + 5'd1;
                    state_reg <= S_ISSUE;
                    if (step_reg == STEP_LR_END && acc_sign)
                        state_reg <= S_SQRT;
                    else if (step_reg == STEP_Q_END)
                    begin
                        hit_reg   <= !acc_sign;
                        state_reg <= S_UPDATE;
                    end
                end
                S_SQRT:
                begin
                    if (sq_done)
                    begin
                        hit_reg   <= 1'b1;
                        state_reg <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    if (!last_reg)
                    begin
                        any_reg       <= m_any;
                        best_dist_reg <= m_dist;
                        best_id_reg   <= m_id;
                        state_reg     <= S_IDLE;
                    end
                    else if (!res_valid_reg || res.ready)
                    begin
                        res_valid_reg <= 1'b1;
                        any_reg       <= 1'b0;
                        best_dist_reg <= DIST_MAX;
                        best_id_reg   <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath words
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && ent.valid)
        begin
            id_reg     <= ent.entity_id;
            pos_reg[0] <= ent.pos_x;
            pos_reg[1] <= ent.pos_y;
            pos_reg[2] <= ent.pos_z;
            scale_reg  <= ent.selection_scale;
            last_reg   <= ent.last;
        end
        if (state_reg == S_PREP_R)
            r_reg <= 32'(scale_reg) + 32'(margin_reg);
        if (state_reg == S_PREP_Y)
            posy_reg <= 34'(pos_reg[1]) + 34'(r_reg[31:1]);
        if (state_reg == S_PREP_OC)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ocs_reg[i] <= oc_next[i][34];
                ocm_reg[i] <= oc_next[i][34] ? MAG_W'(-oc_next[i]) : MAG_W'(oc_next[i]);
            end
        end
        if (state_reg == S_CHECK)
        begin
            case (step_reg)
                STEP_LR_END: lmr_reg <= acc[PROD_W-1:0];
                STEP_D_END:  dd_reg  <= acc[63:0];
                STEP_B_END:  bb_reg  <= acc_sign ? acc_neg[PROD_W-1:0] : acc[PROD_W-1:0];
                default:     ;
            endcase
            if (step_reg == STEP_Q_END)
                dist_reg <= '0;
        end
        if (state_reg == S_SQRT && sq_done)
            dist_reg <= sq_root;
        if (state_reg == S_UPDATE && last_reg && (!res_valid_reg || res.ready))
        begin
            found_reg <= m_any;
            nid_reg   <= m_any ? m_id : '0;
            if (!m_any)
                ndist_reg <= '0;
            else if (m_dist > ROOT_W'(DIST_SAT))
                ndist_reg <= DIST_SAT;
            else
                ndist_reg <= m_dist[SCALE_W-1:0];
        end
    end

    assign ent.ready            = (state_reg == S_IDLE);
    assign cfg.ready            = 1'b1;
    assign res.valid            = res_valid_reg;
    assign res.found            = found_reg;
    assign res.nearest_id       = nid_reg;
    assign res.nearest_distance = ndist_reg;

endmodule

// File: hdl/rsnp_mac.sv
// ----------------------------------------------------------------------------
// rsnp_mac
// Shared 34x34 multiplier with a registered product and a signed
// shift-and-accumulate stage.
// ----------------------------------------------------------------------------
module rsnp_mac
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  rsnp_pkg::mac_op_t       op,
    input  logic [rsnp_pkg::MAG_W-1:0] a,
    input  logic [rsnp_pkg::MAG_W-1:0] b,
    input  logic                    clr,
    output logic [rsnp_pkg::ACC_W-1:0] acc
);

    import rsnp_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    mac_op_t           op_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  term;

    always_comb
    begin
        case (op_reg.shift)
            SH_0:    term = ACC_W'(prod_reg);
            SH_34:   term = ACC_W'(prod_reg) << MAG_W;
            SH_68:   term = ACC_W'(prod_reg) << PROD_W;
            default: term = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg  <= '0;
            acc_reg <= '0;
        end
        else
        begin
            op_reg <= op;
            if (clr)
                acc_reg <= '0;
            else if (op_reg.en)
                acc_reg <= op_reg.sub ? acc_reg - term : acc_reg + term;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign acc = acc_reg;

endmodule

// File: hdl/rsnp_sqrt.sv
// ----------------------------------------------------------------------------
// rsnp_sqrt
// Bit-pair restoring integer square root, 64-bit radicand, one result bit
// per cycle.
// ----------------------------------------------------------------------------
module rsnp_sqrt
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rsnp_pkg::RAD_W-1:0]  radicand,
    output logic                        done,
    output logic [rsnp_pkg::ROOT_W-1:0] root
);

    import rsnp_pkg::*;

    logic [RAD_W-1:0]  x_reg;
    logic [RAD_W-1:0]  res_reg;
    logic [RAD_W-1:0]  bit_reg;
    logic [4:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [RAD_W-1:0]  trial;
    logic              take;

    assign trial = res_reg + bit_reg;
    assign take  = x_reg >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= RAD_W'(1) << (RAD_W - 2);
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                x_reg   <= x_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
                res_reg <= res_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

// File: hdl/rsnp_checker.sv
// ----------------------------------------------------------------------------
// rsnp_checker
// Port-level checks on the nearest pick block, bound to the top level.
// ----------------------------------------------------------------------------
module rsnp_checker #(
    parameter int ID_BITS = 16
) (
    input logic               clk,
    input logic               rst_n,
    input logic               ent_valid,
    input logic               ent_ready,
    input logic               res_valid,
    input logic               res_ready,
    input logic               res_found,
    input logic [ID_BITS-1:0] res_id,
    input logic [30:0]        res_dist
);

    // result word holds while stalled
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_id) && $stable(res_dist)
            && $stable(res_found))
        else $error("result word changed while stalled");

    // a miss reports zero id and distance
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_found |-> res_id == '0 && res_dist == '0)
        else $error("miss result carries non-zero fields");

    // an accepted entity keeps the block busy at the start of set-up
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ent_valid && ent_ready |=> !ent_ready ##1 !ent_ready)
        else $error("entity accepted during computation");

    // a new result word follows a computation
    a_found_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> !ent_ready || $past(!ent_ready))
        else $error("result appeared without a preceding computation");

endmodule

bind ray_sphere_nearest_pick rsnp_checker #(.ID_BITS(ID_BITS)) u_rsnp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .ent_valid (ent.valid),
    .ent_ready (ent.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_found (res.found),
    .res_id    (res.nearest_id),
    .res_dist  (res.nearest_distance)
);
